FILE: src/enf_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// enf_pkg: shared types for the epsilon-NFA matcher
// Item kinds, sequencer states and the control bundle between the sequencer
// and the datapath.
// ---------------------------------------------------------------------------
package enf_pkg;

	// Kind of an input item, carried on s_tuser
	typedef enum logic [1:0] {
		MODE_LOAD_TRANS   = 2'd0,
		MODE_LOAD_CLOSURE = 2'd1,
		MODE_START        = 2'd2,
		MODE_SYMBOL       = 2'd3
	} mode_t;

	// Sequencer states
	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_PASS_TRANS,
		ST_DRAIN_TRANS,
		ST_PASS_CLOSURE,
		ST_DRAIN_CLOSURE,
		ST_FINISH
	} seq_state_t;

	// Control bundle from sequencer to datapath and top level
	typedef struct packed {
		logic idle;         // ready for a new item
		logic clear;        // write zero rows during the clearing pass
		logic load_trans;   // write one transition row
		logic load_closure; // write one closure row
		logic start;        // set up a closure pass over state 0
		logic step;         // set up a transition pass over the active set
		logic issue_trans;  // read one transition row
		logic issue_closure;// read one closure row
		logic swap;         // targets become the selection mask
		logic commit;       // closure union becomes the active set
		logic emit;         // load the output register
	} enf_ctrl_t;

endpackage
`default_nettype wire

FILE: src/enf_ctrl.sv
`default_nettype none
// ---------------------------------------------------------------------------
// enf_ctrl: item sequencer
// Runs the clearing pass after reset; a symbol item then gets a transition
// pass and a closure pass over the states, a start item only the latter.
// ---------------------------------------------------------------------------
module enf_ctrl #(
	parameter int NUM_STATES  = 16,
	parameter int NUM_SYMBOLS = 8,
	localparam int DEPTH      = NUM_STATES * NUM_SYMBOLS,
	localparam int TA_W       = $clog2(DEPTH)
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	input  wire enf_pkg::mode_t      mode,
	input  wire logic                out_free,
	output enf_pkg::enf_ctrl_t       ctrl,
	output logic [TA_W-1:0]          cnt
);
	import enf_pkg::*;

	seq_state_t state_q, state_d;
	logic [TA_W-1:0] cnt_q;
	logic clear_last, pass_last;
	logic accept;

	assign clear_last = (cnt_q == TA_W'(DEPTH - 1));
	assign pass_last  = (cnt_q == TA_W'(NUM_STATES - 1));
	assign cnt        = cnt_q;
	// Input transfer: only taken while idle
	assign accept     = in_valid && (state_q == ST_IDLE);

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (clear_last) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (accept && mode == MODE_START) state_d = ST_PASS_CLOSURE;
				else if (accept && mode == MODE_SYMBOL) state_d = ST_PASS_TRANS;
			end
			ST_PASS_TRANS: begin
				if (pass_last) state_d = ST_DRAIN_TRANS;
			end
			ST_DRAIN_TRANS:   state_d = ST_PASS_CLOSURE;
			ST_PASS_CLOSURE: begin
				if (pass_last) state_d = ST_DRAIN_CLOSURE;
			end
			ST_DRAIN_CLOSURE: state_d = ST_FINISH;
			ST_FINISH: begin
				if (out_free) state_d = ST_IDLE;
			end
			default:          state_d = ST_CLEAR;
		endcase
	end

	// Outputs
	always_comb begin
		ctrl = '0;
		unique case (state_q)
			ST_CLEAR:         ctrl.clear = 1'b1;
			ST_IDLE: begin
				ctrl.idle         = 1'b1;
				ctrl.load_trans   = accept && mode == MODE_LOAD_TRANS;
				ctrl.load_closure = accept && mode == MODE_LOAD_CLOSURE;
				ctrl.start        = accept && mode == MODE_START;
				ctrl.step         = accept && mode == MODE_SYMBOL;
			end
			ST_PASS_TRANS:    ctrl.issue_trans = 1'b1;
			ST_DRAIN_TRANS:   ctrl.swap = 1'b1;
			ST_PASS_CLOSURE:  ctrl.issue_closure = 1'b1;
			ST_DRAIN_CLOSURE: ctrl.commit = 1'b1;
			ST_FINISH:        ctrl.emit = out_free;
			default:          ctrl = '0;
		endcase
	end

	// State register and the shared row counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if ((state_q == ST_CLEAR && !clear_last) ||
			    ((state_q == ST_PASS_TRANS || state_q == ST_PASS_CLOSURE) && !pass_last))
				cnt_q <= cnt_q + 1'b1;
			else
				cnt_q <= '0;
		end
	end

endmodule
`default_nettype wire

FILE: src/enf_datapath.sv
`default_nettype none
// ---------------------------------------------------------------------------
// enf_datapath: row memories and the shared OR-accumulate unit
// Holds the transition and closure rows, the active set, and one accumulator
// that gathers the selected rows of either memory, one row per cycle.
// ---------------------------------------------------------------------------
module enf_datapath #(
	parameter int NUM_STATES  = 16,
	parameter int NUM_SYMBOLS = 8,
	localparam int DEPTH      = NUM_STATES * NUM_SYMBOLS,
	localparam int TA_W       = $clog2(DEPTH),
	localparam int SW         = $clog2(NUM_STATES)
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire enf_pkg::enf_ctrl_t    ctrl,
	input  wire logic [TA_W-1:0]       cnt,
	input  wire logic [3:0]            state_index,
	input  wire logic [2:0]            symbol,
	input  wire logic [15:0]           row_mask,
	output logic [NUM_STATES-1:0]      active
);
	import enf_pkg::*;

	logic [NUM_STATES-1:0] trans_mem [DEPTH];
	logic [NUM_STATES-1:0] clos_mem [NUM_STATES];

	logic [NUM_STATES-1:0] trans_rdata_s1, clos_rdata_s1;
	logic                  hit_s1, from_trans_s1;
	logic [NUM_STATES-1:0] sel_q, acc_q, acc_next, active_q;
	logic [TA_W-1:0]       ta_q;

	logic [31:0]            st32, sym32, load_addr32;
	logic                   st_ok, sym_ok;
	logic [NUM_STATES+15:0] row_ext;
	logic [NUM_STATES-1:0]  row_d;
	logic [SW-1:0]          idx;

	// Decode load addresses and range checks
	assign st32        = 32'(state_index);
	assign sym32       = 32'(symbol);
	assign st_ok       = st32 < 32'(NUM_STATES);
	assign sym_ok      = sym32 < 32'(NUM_SYMBOLS);
	assign load_addr32 = st32 * 32'(NUM_SYMBOLS) + sym32;
	assign row_ext     = {{NUM_STATES{1'b0}}, row_mask};
	assign row_d       = row_ext[NUM_STATES-1:0];
	assign idx         = cnt[SW-1:0];

	// Transition memory: clear sweep or load write, registered read
	always_ff @(posedge clk) begin
		if (ctrl.clear)
			trans_mem[cnt] <= '0;
		else if (ctrl.load_trans && st_ok && sym_ok)
			trans_mem[load_addr32[TA_W-1:0]] <= row_d;
		trans_rdata_s1 <= trans_mem[ta_q];
	end

	// Closure memory: clear sweep or load write, registered read
	always_ff @(posedge clk) begin
		if (ctrl.clear && 32'(cnt) < 32'(NUM_STATES))
			clos_mem[idx] <= '0;
		else if (ctrl.load_closure && st_ok)
			clos_mem[st32[SW-1:0]] <= row_d;
		clos_rdata_s1 <= clos_mem[idx];
	end

	// Shared accumulate unit: OR in the row read last cycle when selected
	always_comb begin
		acc_next = acc_q;
		if (hit_s1)
			acc_next = acc_q | (from_trans_s1 ? trans_rdata_s1 : clos_rdata_s1);
	end

	// Read tags travel alongside the memory read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_s1        <= 1'b0;
			from_trans_s1 <= 1'b0;
		end else begin
			hit_s1        <= (ctrl.issue_trans || ctrl.issue_closure) && sel_q[idx];
			from_trans_s1 <= ctrl.issue_trans;
		end
	end

	// Selection mask, accumulator and transition row address
	always_ff @(posedge clk) begin
		if (ctrl.start) begin
			sel_q <= NUM_STATES'(1);
			acc_q <= '0;
		end else if (ctrl.step) begin
			sel_q <= sym_ok ? active_q : '0;
			acc_q <= '0;
			ta_q  <= sym32[TA_W-1:0];
		end else if (ctrl.swap) begin
			sel_q <= acc_next;
			acc_q <= '0;
		end else begin
			acc_q <= acc_next;
			if (ctrl.issue_trans)
				ta_q <= ta_q + TA_W'(NUM_SYMBOLS);
		end
	end

	// Active set
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			active_q <= '0;
		else if (ctrl.commit)
			active_q <= acc_next;
	end

	assign active = active_q;

endmodule
`default_nettype wire

FILE: src/epsilon_nfa_matcher_core.sv
`default_nettype none
// ---------------------------------------------------------------------------
// epsilon_nfa_matcher_core: epsilon-NFA simulation over a symbol stream
// Loads transition and closure rows, then tracks the active state set per
// symbol and flags when it meets the final-state mask.
//
//   channel | signals                          | content
//   --------+----------------------------------+---------------------------------
//   s_*     | s_tvalid s_tready s_tdata s_tuser | row loads, start, symbol steps
//   m_*     | m_tvalid m_tready m_tdata         | active set and accepted flag
//   cfg_*   | cfg_we cfg_wdata                  | final-state mask
//
// A load is written in the cycle it is accepted. A symbol step reads one
// row per cycle from the transition memory, then one per cycle from the
// closure memory; start reads only the closure memory, from state 0.
// After reset a clearing pass zeroes both memories; s_tready stays low
// until it ends. A result waits in the output register; the next item is
// taken while it waits, but a new result holds until m_tready frees the
// register.
// ---------------------------------------------------------------------------
module epsilon_nfa_matcher_core #(
	parameter int NUM_STATES  = 16,
	parameter int NUM_SYMBOLS = 8
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [23:0] s_tdata,   // [3:0] state_index, [6:4] symbol, [22:7] row_mask
	input  wire logic [1:0]  s_tuser,   // [1:0] mode
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [23:0]      m_tdata,   // [15:0] active_set, [16] accepted
	input  wire logic        cfg_we,
	input  wire logic [15:0] cfg_wdata
);
	import enf_pkg::*;

	localparam int DEPTH = NUM_STATES * NUM_SYMBOLS;
	localparam int TA_W  = $clog2(DEPTH);

	enf_ctrl_t             ctrl;
	logic [TA_W-1:0]       cnt;
	logic [NUM_STATES-1:0] active;
	logic [NUM_STATES+15:0] active_ext;
	logic [15:0]           active16;
	logic                  out_free;
	logic [15:0]           final_q;
	logic                  m_tvalid_q;
	logic [16:0]           m_data_q;

	assign s_tready   = ctrl.idle;
	assign out_free   = !m_tvalid_q || m_tready;
	assign active_ext = {16'd0, active};
	assign active16   = active_ext[15:0];

	enf_ctrl #(
		.NUM_STATES  (NUM_STATES),
		.NUM_SYMBOLS (NUM_SYMBOLS)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.mode     (mode_t'(s_tuser)),
		.out_free (out_free),
		.ctrl     (ctrl),
		.cnt      (cnt)
	);

	enf_datapath #(
		.NUM_STATES  (NUM_STATES),
		.NUM_SYMBOLS (NUM_SYMBOLS)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctrl        (ctrl),
		.cnt         (cnt),
		.state_index (s_tdata[3:0]),
		.symbol      (s_tdata[6:4]),
		.row_mask    (s_tdata[22:7]),
		.active      (active)
	);

	// Final-state mask register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			final_q <= '0;
		else if (cfg_we)
			final_q <= cfg_wdata;
	end

	// Output register: load on emit, drop on transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			m_tvalid_q <= 1'b0;
		else if (ctrl.emit)
			m_tvalid_q <= 1'b1;
		else if (m_tready)
			m_tvalid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (ctrl.emit)
			m_data_q <= {|(active16 & final_q), active16};
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {7'd0, m_data_q};

endmodule
`default_nettype wire
